FILE: rtl/vpsrs_pkg.sv
`timescale 1ns / 1ps

package vpsrs_pkg;

    // Defaults of the top level parameters.
    localparam int DEF_COORD_BITS      = 21;
    localparam int DEF_COORD_FRAC_BITS = 10;
    localparam int DEF_TRIG_FRAC_BITS  = 30;

    // Fixed field widths.
    localparam int TRIG_W    = 32;          // one cosine or sine word
    localparam int COEF_W    = TRIG_W + 1;  // room for a negated sine
    localparam int SNAP_W    = 20;          // grid step
    localparam int PACK_W    = 63;          // packed triple registers
    localparam int ROT_W     = 64;          // packed cosine/sine registers
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIVOT     = 3'd0,
        CFG_SCALE     = 3'd1,
        CFG_TRANSLATE = 3'd2,
        CFG_ROT_X     = 3'd3,
        CFG_ROT_Y     = 3'd4,
        CFG_ROT_Z     = 3'd5,
        CFG_SNAP      = 3'd6
    } t_cfg_idx;

    // Reset value of the scale register: 1.0 in every field that fits.
    function automatic logic [PACK_W-1:0] scale_reset(input int cb, input int fb);
        logic [PACK_W-1:0] v;
        v = '0;
        for (int i = 0; i < 3; i++) begin
            if (i * cb + fb < PACK_W) begin
                v[i * cb + fb] = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/vpsrs_rot.sv
`timescale 1ns / 1ps

// Two-stage plane rotation: a = u*c - w*s, b = u*s + w*c, rounded half up
// and saturated to the input width.
module vpsrs_rot
    import vpsrs_pkg::*;
#(
    parameter int U_W = DEF_COORD_BITS + 2,
    parameter int T_F = DEF_TRIG_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_ce,
    input  logic signed [U_W-1:0] i_u,
    input  logic signed [U_W-1:0] i_w,
    input  logic signed [COEF_W-1:0] i_c,
    input  logic signed [COEF_W-1:0] i_s,
    output logic signed [U_W-1:0] o_a,
    output logic signed [U_W-1:0] o_b
);

    localparam int P_W = U_W + COEF_W;
    localparam int S_W = P_W + 1;
    localparam logic signed [S_W-1:0] HALF = S_W'(64'sd1 <<< (T_F - 1));
    localparam logic signed [S_W-1:0] HI   = S_W'((64'sd1 <<< (U_W - 1)) - 1);
    localparam logic signed [S_W-1:0] LO   = -HI - S_W'(1);

    logic signed [P_W-1:0] r_uc, r_ws, r_us, r_wc;
    logic signed [S_W-1:0] sum_a, sum_b, sh_a, sh_b;
    logic signed [U_W-1:0] n_a, n_b;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_uc <= P_W'(i_u) * P_W'(i_c);
            r_ws <= P_W'(i_w) * P_W'(i_s);
            r_us <= P_W'(i_u) * P_W'(i_s);
            r_wc <= P_W'(i_w) * P_W'(i_c);
            o_a  <= n_a;
            o_b  <= n_b;
        end
    end

    always_comb begin
        sum_a = S_W'(r_uc) - S_W'(r_ws) + HALF;
        sum_b = S_W'(r_us) + S_W'(r_wc) + HALF;
        sh_a  = sum_a >>> T_F;
        sh_b  = sum_b >>> T_F;
        n_a   = (sh_a > HI) ? U_W'(HI) : ((sh_a < LO) ? U_W'(LO) : U_W'(sh_a));
        n_b   = (sh_b > HI) ? U_W'(HI) : ((sh_b < LO) ? U_W'(LO) : U_W'(sh_b));
    end

endmodule

FILE: rtl/vpsrs_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside the dividend.
module vpsrs_div
    import vpsrs_pkg::*;
#(
    parameter int A_W  = DEF_COORD_BITS + 3,
    parameter int SB_W = DEF_COORD_BITS + 4
) (
    input  logic              i_clk,
    input  logic              i_ce,
    input  logic [SNAP_W-1:0] i_g,
    input  logic [A_W-1:0]    i_a,
    input  logic [SB_W-1:0]   i_sb,
    output logic [A_W-1:0]    o_q,
    output logic [SNAP_W-1:0] o_rem,
    output logic [SB_W-1:0]   o_sb
);

    logic [SNAP_W-1:0] r_rem [A_W];
    logic [A_W-1:0]    r_q   [A_W];
    logic [A_W-1:0]    r_a   [A_W];
    logic [SB_W-1:0]   r_sb  [A_W];

    for (genvar k = 0; k < A_W; k++) begin : g_stage
        logic [SNAP_W-1:0] p_rem;
        logic [A_W-1:0]    p_q, p_a;
        logic [SB_W-1:0]   p_sb;
        logic [SNAP_W:0]   trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_q   = '0;
            assign p_a   = i_a;
            assign p_sb  = i_sb;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_q   = r_q[k-1];
            assign p_a   = r_a[k-1];
            assign p_sb  = r_sb[k-1];
        end

        assign trial = {p_rem, p_a[A_W-1-k]};
        assign ge    = trial >= {1'b0, i_g};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= ge ? SNAP_W'(trial - {1'b0, i_g}) : SNAP_W'(trial);
                r_q[k]   <= {p_q[A_W-2:0], ge};
                r_a[k]   <= p_a;
                r_sb[k]  <= p_sb;
            end
        end
    end

    assign o_q   = r_q[A_W-1];
    assign o_rem = r_rem[A_W-1];
    assign o_sb  = r_sb[A_W-1];

endmodule

FILE: rtl/vertex_pivot_scale_rotate_snap_core.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline advances together unless
// a valid result at the output is stalled. The snap divider, one quotient bit
// per stage, sets most of the depth.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.

module vertex_pivot_scale_rotate_snap_core
    import vpsrs_pkg::*;
#(
    parameter int COORD_BITS      = DEF_COORD_BITS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int TRIG_FRAC_BITS  = DEF_TRIG_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic                         i_mirror_side,
    // Result item channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic                         o_moved,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int D_W   = CB + 1;          // vertex minus pivot
    localparam int P_W   = 2 * CB + 1;      // scaled product
    localparam int U_W   = CB + 2;          // saturated intermediate coordinate
    localparam int RES_W = CB + 3;          // pivot + rotated + translation
    localparam int MAG_W = RES_W;           // magnitude into the divider
    localparam int SB_W  = RES_W + 1;       // sign and raw sum beside the divider
    localparam int QF_W  = MAG_W + 1;
    localparam int QR_W  = MAG_W + 2;
    localparam int M_W   = QR_W + SNAP_W + 1;
    localparam int L     = MAG_W + 15;      // pipeline depth
    localparam int PAD_W = (3 * CB > CFG_DAT_W) ? 3 * CB : CFG_DAT_W;
    localparam int SD_W  = 3 * CB + 1;      // input vertex and mirror flag
    localparam int MIR_POS = 3 * CB;

    localparam logic signed [P_W:0] W_HALF = (P_W+1)'(64'sd1 <<< (COORD_FRAC_BITS - 1));
    localparam logic signed [P_W:0] W_HI   = (P_W+1)'((64'sd1 <<< (U_W - 1)) - 1);
    localparam logic signed [P_W:0] W_LO   = -W_HI - (P_W+1)'(1);
    localparam logic signed [M_W-1:0] O_HI = M_W'((64'sd1 <<< (CB - 1)) - 1);
    localparam logic signed [M_W-1:0] O_LO = -O_HI - M_W'(1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the pipeline is
    // empty (the block itself does not enforce this); every stage reads them directly.
    // ------------------------------------------------------------------
    logic [PACK_W-1:0] r_pivot, r_scale, r_trans;
    logic [ROT_W-1:0]  r_rot_x, r_rot_y, r_rot_z;
    logic [SNAP_W-1:0] r_snap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot <= '0;
            r_scale <= scale_reset(CB, COORD_FRAC_BITS);
            r_trans <= '0;
            r_rot_x <= ROT_W'(64'd1 << TRIG_FRAC_BITS);
            r_rot_y <= ROT_W'(64'd1 << TRIG_FRAC_BITS);
            r_rot_z <= ROT_W'(64'd1 << TRIG_FRAC_BITS);
            r_snap  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PIVOT:     r_pivot <= i_cfg_data[PACK_W-1:0];
                CFG_SCALE:     r_scale <= i_cfg_data[PACK_W-1:0];
                CFG_TRANSLATE: r_trans <= i_cfg_data[PACK_W-1:0];
                CFG_ROT_X:     r_rot_x <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_Y:     r_rot_y <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_Z:     r_rot_z <= i_cfg_data[ROT_W-1:0];
                CFG_SNAP:      r_snap  <= i_cfg_data[SNAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Packed fields; bits above the register read as zero.
    logic [PAD_W-1:0] pivot_ext, scale_ext, trans_ext;
    logic signed [CB-1:0] pv [3];
    logic signed [CB-1:0] sc [3];
    logic signed [CB-1:0] tv [3];

    assign pivot_ext = PAD_W'(r_pivot);
    assign scale_ext = PAD_W'(r_scale);
    assign trans_ext = PAD_W'(r_trans);

    for (genvar a = 0; a < 3; a++) begin : g_field
        assign pv[a] = $signed(pivot_ext[a*CB +: CB]);
        assign sc[a] = $signed(scale_ext[a*CB +: CB]);
        assign tv[a] = $signed(trans_ext[a*CB +: CB]);
    end

    // Rotation coefficients. The Y rotation uses the same plane rotation
    // with its sine negated.
    logic signed [COEF_W-1:0] cx, sx, cy, sy_n, cz, sz;
    assign cx   = COEF_W'($signed(r_rot_x[TRIG_W-1:0]));
    assign sx   = COEF_W'($signed(r_rot_x[ROT_W-1:TRIG_W]));
    assign cy   = COEF_W'($signed(r_rot_y[TRIG_W-1:0]));
    assign sy_n = -COEF_W'($signed(r_rot_y[ROT_W-1:TRIG_W]));
    assign cz   = COEF_W'($signed(r_rot_z[TRIG_W-1:0]));
    assign sz   = COEF_W'($signed(r_rot_z[ROT_W-1:TRIG_W]));

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together unless a finished
    // result is held by the consumer. Bubbles travel as cleared valid bits.
    // ------------------------------------------------------------------
    logic         ce, acc;
    logic [L-1:0] r_vld;

    assign ce      = !(r_vld[L-1] && i_stall);
    assign o_stall = !ce;
    assign acc     = i_valid && ce;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[L-2:0], acc};
        end
    end

    // Input vertex and mirror flag, carried beside the datapath for the
    // translation sign and the final change test.
    logic [SD_W-1:0] r_side [L-1];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= {i_mirror_side, i_vertex_z, i_vertex_y, i_vertex_x};
            for (int k = 1; k < L - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 to 3: subtract the pivot, scale, round half up, saturate.
    // ------------------------------------------------------------------
    logic signed [CB-1:0]  vin [3];
    logic signed [D_W-1:0] r_d [3];
    logic signed [P_W-1:0] r_prod [3];
    logic signed [U_W-1:0] r_w [3];
    logic signed [P_W:0]   s3_sh [3];

    assign vin[0] = i_vertex_x;
    assign vin[1] = i_vertex_y;
    assign vin[2] = i_vertex_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s3_sh[a] = ((P_W+1)'(r_prod[a]) + W_HALF) >>> COORD_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 3; a++) begin
                r_d[a]    <= D_W'(vin[a]) - D_W'(pv[a]);
                r_prod[a] <= P_W'(r_d[a]) * P_W'(sc[a]);
                r_w[a]    <= (s3_sh[a] > W_HI) ? U_W'(W_HI) :
                             ((s3_sh[a] < W_LO) ? U_W'(W_LO) : U_W'(s3_sh[a]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 9: rotate about X, then Y, then Z, two stages each. The
    // axis that a rotation leaves alone is delayed to stay in step.
    // ------------------------------------------------------------------
    logic signed [U_W-1:0] x_ny, x_nz, y_nx, y_nz, z_nx, z_ny;
    logic signed [U_W-1:0] r_cx1, r_cx2, r_cy1, r_cy2, r_cz1, r_cz2;

    vpsrs_rot #(.U_W(U_W), .T_F(TRIG_FRAC_BITS)) u_rot_x (
        .i_clk(i_clk), .i_ce(ce), .i_u(r_w[1]), .i_w(r_w[2]),
        .i_c(cx), .i_s(sx), .o_a(x_ny), .o_b(x_nz)
    );

    vpsrs_rot #(.U_W(U_W), .T_F(TRIG_FRAC_BITS)) u_rot_y (
        .i_clk(i_clk), .i_ce(ce), .i_u(r_cx2), .i_w(x_nz),
        .i_c(cy), .i_s(sy_n), .o_a(y_nx), .o_b(y_nz)
    );

    vpsrs_rot #(.U_W(U_W), .T_F(TRIG_FRAC_BITS)) u_rot_z (
        .i_clk(i_clk), .i_ce(ce), .i_u(y_nx), .i_w(r_cy2),
        .i_c(cz), .i_s(sz), .o_a(z_nx), .o_b(z_ny)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cx1 <= r_w[0];
            r_cx2 <= r_cx1;
            r_cy1 <= x_ny;
            r_cy2 <= r_cy1;
            r_cz1 <= y_nz;
            r_cz2 <= r_cz1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: add back the pivot and the translation (X translation
    // negated for a mirrored vertex). Stage 11: split into sign and
    // magnitude for the divider.
    // ------------------------------------------------------------------
    logic signed [U_W-1:0]   rot_out [3];
    logic signed [RES_W-1:0] r_res [3];
    logic signed [RES_W-1:0] r_sres [3];
    logic [MAG_W-1:0]        r_mag [3];
    logic                    r_neg [3];
    logic                    mir;

    assign rot_out[0] = z_nx;
    assign rot_out[1] = z_ny;
    assign rot_out[2] = r_cz2;
    assign mir        = r_side[8][MIR_POS];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 3; a++) begin
                r_res[a] <= RES_W'(pv[a]) + RES_W'(rot_out[a]) +
                            ((a == 0 && mir) ? -RES_W'(tv[a]) : RES_W'(tv[a]));
                r_neg[a]  <= r_res[a] < 0;
                r_mag[a]  <= (r_res[a] < 0) ? MAG_W'(-r_res[a]) : MAG_W'(r_res[a]);
                r_sres[a] <= r_res[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: magnitude divided by the grid step, one per axis.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]  dq   [3];
    logic [SNAP_W-1:0] drem [3];
    logic [SB_W-1:0]   dsb  [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        vpsrs_div #(.A_W(MAG_W), .SB_W(SB_W)) u_div (
            .i_clk(i_clk), .i_ce(ce), .i_g(r_snap), .i_a(r_mag[a]),
            .i_sb({r_neg[a], r_sres[a]}),
            .o_q(dq[a]), .o_rem(drem[a]), .o_sb(dsb[a])
        );
    end

    // ------------------------------------------------------------------
    // Floor correction, round to nearest with ties to even, multiply back,
    // then saturate into the output register. A zero grid step skips the snap
    // and passes the sum straight to the saturation.
    // ------------------------------------------------------------------
    logic signed [QF_W-1:0]  r_qf [3];
    logic [SNAP_W-1:0]       r_rf [3];
    logic signed [RES_W-1:0] r_fres [3];
    logic signed [QR_W-1:0]  r_qr [3];
    logic signed [RES_W-1:0] r_rres [3];
    logic signed [M_W-1:0]   r_m [3];
    logic signed [QF_W-1:0]  q0s [3];
    logic                    up [3];
    logic signed [CB-1:0]    n_out [3];
    logic signed [CB-1:0]    vold [3];
    logic                    n_moved;

    always_comb begin
        n_moved = 1'b0;
        for (int a = 0; a < 3; a++) begin
            q0s[a]  = $signed({1'b0, dq[a]});
            up[a]   = ({1'b0, r_rf[a], 1'b0} > {2'b00, r_snap}) ||
                      (({1'b0, r_rf[a], 1'b0} == {2'b00, r_snap}) && r_qf[a][0]);
            n_out[a] = (r_m[a] > O_HI) ? CB'(O_HI) :
                       ((r_m[a] < O_LO) ? CB'(O_LO) : CB'(r_m[a]));
            vold[a]  = $signed(r_side[L-2][a*CB +: CB]);
            if (n_out[a] != vold[a]) begin
                n_moved = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 3; a++) begin
                if (!dsb[a][SB_W-1]) begin
                    r_qf[a] <= q0s[a];
                    r_rf[a] <= drem[a];
                end else if (drem[a] == '0) begin
                    r_qf[a] <= -q0s[a];
                    r_rf[a] <= '0;
                end else begin
                    r_qf[a] <= -q0s[a] - QF_W'(1);
                    r_rf[a] <= r_snap - drem[a];
                end
                r_fres[a] <= $signed(dsb[a][RES_W-1:0]);

                r_qr[a]   <= QR_W'(r_qf[a]) + (up[a] ? QR_W'(1) : QR_W'(0));
                r_rres[a] <= r_fres[a];

                r_m[a] <= (r_snap == '0) ? M_W'(r_rres[a]) :
                          M_W'(r_qr[a]) * M_W'($signed({1'b0, r_snap}));
            end
            o_out_x <= n_out[0];
            o_out_y <= n_out[1];
            o_out_z <= n_out[2];
            o_moved <= n_moved;
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while the output stage is empty");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_moved) && $stable(r_vld)))
        else $error("pipeline moved while the result was held");

endmodule
